// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the waypoint sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WPS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("waypoint sequencer assertion failed");
`define WPS_ASSERT_NEVER(label, clk, rst_n, expr) \
  `WPS_ASSERT(label, clk, rst_n, !(expr))
`else
`define WPS_ASSERT(label, clk, rst_n, prop)
`define WPS_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- rtl/wps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint sequencer package
// Codes, fixed field widths and the types shared by the sequencer modules.
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int KIND_W    = 2;
  localparam int EV_W      = 2;
  localparam int RAD_W     = 16;
  localparam int TIDX_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  localparam logic [EV_W-1:0] EV_RESET    = 2'd0;
  localparam logic [EV_W-1:0] EV_WAYPOINT = 2'd1;
  localparam logic [EV_W-1:0] EV_COMPLETE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_RADIUS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_LIMIT = 2'd2;

  localparam logic [RAD_W-1:0] ACCEPT_RADIUS_RST   = 16'd400;
  localparam logic [RAD_W-1:0] FINAL_RADIUS_RST    = 16'd250;
  localparam logic [RAD_W-1:0] DEVIATION_LIMIT_RST = 16'd2000;

  // Which quantity a sum of squares from the shared unit belongs to.
  typedef enum logic [1:0] {
    TAG_RSQ,
    TAG_DEVSQ,
    TAG_D2,
    TAG_HOR
  } sq_tag_e;

  // One operation issued to the square-accumulate unit.
  typedef struct packed {
    logic    valid;
    logic    clr;
    logic    last;
    sq_tag_e tag;
  } sq_ctl_t;

  // A finished sum leaving the unit.
  typedef struct packed {
    logic    valid;
    sq_tag_e tag;
  } sq_stat_t;

endpackage

// ----- rtl/wps_path_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint path memory
// Single write port, single registered read port storing path points.
// ----------------------------------------------------------------------------
module wps_path_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 72
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data only changes when a read is requested, so it can be held.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/wps_sq_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square-accumulate unit
// Pipelined (a - b)^2 with a running sum; one operation per cycle.
// ----------------------------------------------------------------------------
module wps_sq_unit #(
  parameter int OP_W = 25
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wps_pkg::sq_ctl_t        req_i,
  input  logic [OP_W-1:0]         a_i,
  input  logic [OP_W-1:0]         b_i,
  output wps_pkg::sq_stat_t       stat_o,
  output logic [2*OP_W+3:0]       sum_o,
  output logic                    busy_o
);

  localparam int ACC_W = 2 * OP_W + 4;

  wps_pkg::sq_ctl_t          s1_q;
  wps_pkg::sq_ctl_t          s2_q;
  logic signed [OP_W:0]      diff_d;
  logic signed [OP_W:0]      diff_q;
  logic signed [2*OP_W+1:0]  prod;
  logic [2*OP_W+1:0]         sq_q;
  logic [ACC_W-1:0]          acc_q;
  logic                      res_valid_q;
  wps_pkg::sq_tag_e          res_tag_q;

  assign diff_d = $signed({a_i[OP_W-1], a_i}) - $signed({b_i[OP_W-1], b_i});
  assign prod   = diff_q * diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      diff_q      <= '0;
      sq_q        <= '0;
      acc_q       <= '0;
      res_valid_q <= 1'b0;
      res_tag_q   <= wps_pkg::TAG_RSQ;
    end else begin
      s1_q <= req_i;
      if (req_i.valid) begin
        diff_q <= diff_d;
      end
      s2_q <= s1_q;
      if (s1_q.valid) begin
        sq_q <= prod;
      end
      res_valid_q <= s2_q.valid && s2_q.last;
      if (s2_q.valid) begin
        res_tag_q <= s2_q.tag;
        if (s2_q.clr) begin
          acc_q <= {2'b00, sq_q};
        end else begin
          acc_q <= acc_q + {2'b00, sq_q};
        end
      end
    end
  end

  assign stat_o.valid = res_valid_q;
  assign stat_o.tag   = res_tag_q;
  assign sum_o        = acc_q;
  assign busy_o       = s1_q.valid || s2_q.valid || res_valid_q;

endmodule

// ----- rtl/waypoint_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint sequencer core
// Follows a stored 3-D path with acceptance radii and flags path deviation.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the input channel (in_valid_i / in_ready_o) and
// carry a kind: path point load, drone position update or update tick.
// Results leave on the output channel (out_valid_o / out_ready_i) from an
// output register. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must do so only while the block is
// idle, as the block itself does not enforce it. Loads and position
// updates are taken in the idle state. A load that starts a new path
// answers with a reset notice, passing through the emit state into the
// output register. During a tick the single square-accumulate unit forms
// two products per path point while the deviation minimum is swept
// through the path memory.
// Only one request is in work at a time; in_ready_o is high in the idle
// state, also while a finished result still waits in the output register.
// When the receiver stalls, a new result waits in its final state until the
// output register frees, and then the block returns to idle.
// Reset clears the path, the position and the flags and restores the
// default radii; the path memory itself is not cleared and needs no pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module waypoint_sequencer_core #(
  parameter int PATH_DEPTH = 256,
  parameter int COORD_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [wps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [wps_pkg::RAD_W-1:0]           cfg_wdata_i,
  // Input requests.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [wps_pkg::KIND_W-1:0]          kind_i,
  input  logic signed [COORD_BITS-1:0]        pos_x_i,
  input  logic signed [COORD_BITS-1:0]        pos_y_i,
  input  logic signed [COORD_BITS-1:0]        pos_z_i,
  input  logic                                first_point_i,
  input  logic                                last_point_i,
  // Result outputs.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wps_pkg::EV_W-1:0]            event_res_o,
  output logic signed [COORD_BITS-1:0]        target_x_o,
  output logic signed [COORD_BITS-1:0]        target_y_o,
  output logic signed [COORD_BITS-1:0]        target_z_o,
  output logic [wps_pkg::TIDX_W-1:0]          target_index_o,
  output logic                                replan_request_o,
  output logic signed [COORD_BITS-1:0]        goal_x_o,
  output logic signed [COORD_BITS-1:0]        goal_y_o,
  output logic signed [COORD_BITS-1:0]        goal_z_o
);

  localparam int IDX_W      = $clog2(PATH_DEPTH);
  localparam int CNT_W      = $clog2(PATH_DEPTH + 1);
  localparam int PT_W       = 3 * COORD_BITS;
  localparam int OP_W       = COORD_BITS + 1;
  localparam int ACC_W      = 2 * OP_W + 4;
  localparam int TIDX_EXT_W = (IDX_W > wps_pkg::TIDX_W) ? IDX_W : wps_pkg::TIDX_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TCHK,
    S_DEVSQ,
    S_WPX,
    S_WPY,
    S_WPZ,
    S_WAITD,
    S_SCAN_RD,
    S_SCAN_X,
    S_SCAN_Y,
    S_DRAIN,
    S_EMIT
  } state_e;

  state_e                       state_q;

  // Configuration registers.
  logic [wps_pkg::RAD_W-1:0]    accept_radius_q;
  logic [wps_pkg::RAD_W-1:0]    final_radius_q;
  logic [wps_pkg::RAD_W-1:0]    deviation_limit_q;

  // Path bookkeeping and drone state.
  logic [CNT_W-1:0]             count_q;
  logic [IDX_W-1:0]             idx_q;
  logic                         path_active_q;
  logic                         mission_done_q;
  logic                         have_pos_q;
  logic [COORD_BITS-1:0]        drone_x_q;
  logic [COORD_BITS-1:0]        drone_y_q;
  logic [COORD_BITS-1:0]        drone_z_q;
  logic [PT_W-1:0]              goal_q;

  // Tick working registers.
  logic                         final_q;
  logic [IDX_W-1:0]             scan_q;
  logic [ACC_W-1:0]             rsq_q;
  logic [ACC_W-1:0]             devsq_q;
  logic [ACC_W-1:0]             best_q;
  logic [wps_pkg::EV_W-1:0]     ev_q;

  // Output register.
  logic                         out_valid_q;
  logic [wps_pkg::EV_W-1:0]     event_q;
  logic [COORD_BITS-1:0]        target_x_q;
  logic [COORD_BITS-1:0]        target_y_q;
  logic [COORD_BITS-1:0]        target_z_q;
  logic [wps_pkg::TIDX_W-1:0]   target_index_q;
  logic                         replan_q;
  logic [PT_W-1:0]              goal_out_q;

  // Memory and unit hookup.
  logic                         in_acc;
  logic                         is_load;
  logic [CNT_W-1:0]             load_cnt;
  logic                         mem_we;
  logic                         mem_re;
  logic [IDX_W-1:0]             mem_raddr;
  logic [PT_W-1:0]              mem_rdata;
  logic [PT_W-1:0]              in_point;
  logic [COORD_BITS-1:0]        wp_x;
  logic [COORD_BITS-1:0]        wp_y;
  logic [COORD_BITS-1:0]        wp_z;
  wps_pkg::sq_ctl_t             sq_req;
  logic [OP_W-1:0]              sq_a;
  logic [OP_W-1:0]              sq_b;
  wps_pkg::sq_stat_t            sq_stat;
  logic [ACC_W-1:0]             sq_sum;
  logic                         sq_busy;

  logic                         tick_ok;
  logic [IDX_W-1:0]             idx_clamp;
  logic                         final_c;
  logic                         scan_more;
  logic                         out_free;
  logic [TIDX_EXT_W-1:0]        idx_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_load    = in_acc && (kind_i == wps_pkg::KIND_LOAD);
  assign out_free   = !out_valid_q || out_ready_i;

  // A first point restarts the path, so its slot is always zero.
  assign load_cnt = first_point_i ? '0 : count_q;
  assign mem_we   = is_load && (load_cnt < CNT_W'(PATH_DEPTH));
  assign in_point = {pos_x_i, pos_y_i, pos_z_i};

  assign wp_x = mem_rdata[PT_W-1 -: COORD_BITS];
  assign wp_y = mem_rdata[2*COORD_BITS-1 -: COORD_BITS];
  assign wp_z = mem_rdata[COORD_BITS-1:0];

  // Tick preconditions and the index clamp, evaluated in the check state.
  assign tick_ok   = path_active_q && have_pos_q && !mission_done_q && (count_q != '0);
  assign idx_clamp = (CNT_W'(idx_q) >= count_q) ? IDX_W'(count_q - 1'b1) : idx_q;
  assign final_c   = (CNT_W'(idx_clamp) + 1'b1) >= count_q;
  assign scan_more = (CNT_W'(scan_q) + 1'b1) < count_q;
  assign idx_ext   = TIDX_EXT_W'(idx_q);

  // Memory read and shared unit operand selection per sequencer step.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    sq_req    = '0;
    sq_a      = '0;
    sq_b      = '0;
    unique case (state_q)
      S_TCHK: begin
        mem_re    = tick_ok;
        mem_raddr = idx_clamp;
        sq_req    = '{valid: tick_ok, clr: 1'b1, last: 1'b1, tag: wps_pkg::TAG_RSQ};
        sq_a      = {{(OP_W - wps_pkg::RAD_W){1'b0}},
                     (final_c ? final_radius_q : accept_radius_q)};
      end
      S_DEVSQ: begin
        sq_req = '{valid: 1'b1, clr: 1'b1, last: 1'b1, tag: wps_pkg::TAG_DEVSQ};
        sq_a   = {{(OP_W - wps_pkg::RAD_W){1'b0}}, deviation_limit_q};
      end
      S_WPX: begin
        sq_req = '{valid: 1'b1, clr: 1'b1, last: 1'b0, tag: wps_pkg::TAG_D2};
        sq_a   = {drone_x_q[COORD_BITS-1], drone_x_q};
        sq_b   = {wp_x[COORD_BITS-1], wp_x};
      end
      S_WPY: begin
        sq_req = '{valid: 1'b1, clr: 1'b0, last: 1'b0, tag: wps_pkg::TAG_D2};
        sq_a   = {drone_y_q[COORD_BITS-1], drone_y_q};
        sq_b   = {wp_y[COORD_BITS-1], wp_y};
      end
      S_WPZ: begin
        sq_req = '{valid: 1'b1, clr: 1'b0, last: 1'b1, tag: wps_pkg::TAG_D2};
        sq_a   = {drone_z_q[COORD_BITS-1], drone_z_q};
        sq_b   = {wp_z[COORD_BITS-1], wp_z};
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      S_SCAN_X: begin
        sq_req = '{valid: 1'b1, clr: 1'b1, last: 1'b0, tag: wps_pkg::TAG_HOR};
        sq_a   = {drone_x_q[COORD_BITS-1], drone_x_q};
        sq_b   = {wp_x[COORD_BITS-1], wp_x};
      end
      S_SCAN_Y: begin
        // The next point is fetched only after this step has taken its operand.
        sq_req    = '{valid: 1'b1, clr: 1'b0, last: 1'b1, tag: wps_pkg::TAG_HOR};
        sq_a      = {drone_y_q[COORD_BITS-1], drone_y_q};
        sq_b      = {wp_y[COORD_BITS-1], wp_y};
        mem_re    = scan_more;
        mem_raddr = scan_q + 1'b1;
      end
      S_DRAIN: begin
        // Fetch the current waypoint again; the index may have moved on.
        mem_re    = 1'b1;
        mem_raddr = idx_q;
      end
      default: begin
      end
    endcase
  end

  wps_path_mem #(
    .DEPTH (PATH_DEPTH),
    .WIDTH (PT_W)
  ) u_path_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (load_cnt[IDX_W-1:0]),
    .wdata_i (in_point),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  wps_sq_unit #(
    .OP_W (OP_W)
  ) u_sq_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .a_i    (sq_a),
    .b_i    (sq_b),
    .stat_o (sq_stat),
    .sum_o  (sq_sum),
    .busy_o (sq_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      accept_radius_q   <= wps_pkg::ACCEPT_RADIUS_RST;
      final_radius_q    <= wps_pkg::FINAL_RADIUS_RST;
      deviation_limit_q <= wps_pkg::DEVIATION_LIMIT_RST;
      count_q           <= '0;
      idx_q             <= '0;
      path_active_q     <= 1'b0;
      mission_done_q    <= 1'b0;
      have_pos_q        <= 1'b0;
      drone_x_q         <= '0;
      drone_y_q         <= '0;
      drone_z_q         <= '0;
      goal_q            <= '0;
      final_q           <= 1'b0;
      scan_q            <= '0;
      rsq_q             <= '0;
      devsq_q           <= '0;
      best_q            <= '0;
      ev_q              <= wps_pkg::EV_RESET;
      out_valid_q       <= 1'b0;
      event_q           <= wps_pkg::EV_RESET;
      target_x_q        <= '0;
      target_y_q        <= '0;
      target_z_q        <= '0;
      target_index_q    <= '0;
      replan_q          <= 1'b0;
      goal_out_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          wps_pkg::CFG_ACCEPT_RADIUS:   accept_radius_q   <= cfg_wdata_i;
          wps_pkg::CFG_FINAL_RADIUS:    final_radius_q    <= cfg_wdata_i;
          wps_pkg::CFG_DEVIATION_LIMIT: deviation_limit_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      // Shared-unit radius and limit sums are stored; scan sums keep a minimum.
      if (sq_stat.valid) begin
        unique case (sq_stat.tag)
          wps_pkg::TAG_RSQ:   rsq_q   <= sq_sum;
          wps_pkg::TAG_DEVSQ: devsq_q <= sq_sum;
          wps_pkg::TAG_HOR: begin
            if (sq_sum < best_q) begin
              best_q <= sq_sum;
            end
          end
          wps_pkg::TAG_D2: begin
          end
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (kind_i)
              wps_pkg::KIND_LOAD: begin
                if (first_point_i) begin
                  idx_q          <= '0;
                  path_active_q  <= 1'b0;
                  mission_done_q <= 1'b0;
                  count_q        <= '0;
                  ev_q           <= wps_pkg::EV_RESET;
                  state_q        <= S_EMIT;
                end
                if (mem_we) begin
                  count_q <= load_cnt + 1'b1;
                  goal_q  <= in_point;
                end
                if (last_point_i) begin
                  path_active_q <= 1'b1;
                end
              end
              wps_pkg::KIND_POS: begin
                drone_x_q  <= pos_x_i;
                drone_y_q  <= pos_y_i;
                drone_z_q  <= pos_z_i;
                have_pos_q <= 1'b1;
              end
              wps_pkg::KIND_TICK: begin
                state_q <= S_TCHK;
              end
              default: begin
              end
            endcase
          end
        end
        S_TCHK: begin
          if (tick_ok) begin
            idx_q   <= idx_clamp;
            final_q <= final_c;
            state_q <= S_DEVSQ;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DEVSQ: state_q <= S_WPX;
        S_WPX:   state_q <= S_WPY;
        S_WPY:   state_q <= S_WPZ;
        S_WPZ:   state_q <= S_WAITD;
        S_WAITD: begin
          if (sq_stat.valid && (sq_stat.tag == wps_pkg::TAG_D2)) begin
            if ((sq_sum < rsq_q) && final_q) begin
              mission_done_q <= 1'b1;
              ev_q           <= wps_pkg::EV_COMPLETE;
              state_q        <= S_EMIT;
            end else begin
              if (sq_sum < rsq_q) begin
                idx_q <= idx_q + 1'b1;
              end
              ev_q    <= wps_pkg::EV_WAYPOINT;
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          scan_q  <= '0;
          best_q  <= '1;
          state_q <= S_SCAN_X;
        end
        S_SCAN_X: state_q <= S_SCAN_Y;
        S_SCAN_Y: begin
          if (scan_more) begin
            scan_q  <= scan_q + 1'b1;
            state_q <= S_SCAN_X;
          end else begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!sq_busy) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            event_q        <= ev_q;
            target_x_q     <= (ev_q == wps_pkg::EV_WAYPOINT) ? wp_x : '0;
            target_y_q     <= (ev_q == wps_pkg::EV_WAYPOINT) ? wp_y : '0;
            target_z_q     <= (ev_q == wps_pkg::EV_WAYPOINT) ? wp_z : '0;
            target_index_q <= (ev_q == wps_pkg::EV_RESET) ? '0
                                                          : idx_ext[wps_pkg::TIDX_W-1:0];
            replan_q       <= (ev_q == wps_pkg::EV_WAYPOINT) && (best_q > devsq_q);
            goal_out_q     <= (ev_q == wps_pkg::EV_RESET) ? '0 : goal_q;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = event_q;
  assign target_x_o       = target_x_q;
  assign target_y_o       = target_y_q;
  assign target_z_o       = target_z_q;
  assign target_index_o   = target_index_q;
  assign replan_request_o = replan_q;
  assign goal_x_o         = goal_out_q[PT_W-1 -: COORD_BITS];
  assign goal_y_o         = goal_out_q[2*COORD_BITS-1 -: COORD_BITS];
  assign goal_z_o         = goal_out_q[COORD_BITS-1:0];

  // The waypoint index always points into the stored path.
  `WPS_ASSERT(a_idx_in_path, clk_i, rst_ni, (count_q != '0) |-> (CNT_W'(idx_q) < count_q))
  // A finished mission belongs to an active path.
  `WPS_ASSERT(a_done_needs_path, clk_i, rst_ni, mission_done_q |-> path_active_q)
  // The shared unit has drained whenever the block is back in idle.
  `WPS_ASSERT_NEVER(a_idle_unit_quiet, clk_i, rst_ni, (state_q == S_IDLE) && sq_busy)
  // A replan flag only comes with a waypoint result.
  `WPS_ASSERT(a_replan_on_wp, clk_i, rst_ni,
    (out_valid_o && replan_request_o) |-> (event_res_o == wps_pkg::EV_WAYPOINT))

endmodule
